@@ rtl/bucketed_vector_engine_defines.svh @@
// assertion macros shared by the block
`ifndef BUCKETED_VECTOR_ENGINE_DEFINES_SVH
`define BUCKETED_VECTOR_ENGINE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bve_pkg.sv @@
package bve_pkg;

    // default sizing
    localparam int FIRST_BUCKET_DEF = 2;
    localparam int LEVELS_DEF       = 8;
    localparam int DATA_WIDTH_DEF   = 32;

    // port field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int BUCKET_W = 3;
    localparam int OFFSET_W = 8;

    // operation codes
    localparam logic [KIND_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] OP_POP   = 2'd1;
    localparam logic [KIND_W-1:0] OP_READ  = 2'd2;
    localparam logic [KIND_W-1:0] OP_WRITE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic load;
    } bve_cmd_t;

endpackage

@@ rtl/bucketed_vector_engine.sv @@
// Growable vector of data words with push back, pop back, indexed read and
// indexed write. One item in gives one item out.
// Input channel: in_valid / in_stall with kind, index and value_in.
// Output channel: out_valid / out_stall with status, value_out, count,
// room, bucket and offset.
// Sequence: at the input accept the memory access is issued and the
// operation is registered; the result is then loaded into the output
// register once that register is free.
// Pacing: no new item is taken until the last one is loaded, as the
// single-port element memory and its registered read give one access per item.
// Reset: count returns to zero and room to FIRST_BUCKET; the element memory
// keeps its contents and needs no clearing pass, since only written entries
// below the count are ever read.
// When the receiver stalls, the finished result holds in the output
// register; one more item is taken meanwhile and waits for that register.
`include "bucketed_vector_engine_defines.svh"

module bucketed_vector_engine #(
    parameter int FIRST_BUCKET = bve_pkg::FIRST_BUCKET_DEF,
    parameter int LEVELS       = bve_pkg::LEVELS_DEF,
    parameter int DATA_WIDTH   = bve_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bve_pkg::KIND_W-1:0]          kind,
    input  logic [bve_pkg::INDEX_W-1:0]         index,
    input  logic signed [bve_pkg::VALUE_W-1:0]  value_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bve_pkg::STATUS_W-1:0]        status,
    output logic signed [bve_pkg::VALUE_W-1:0]  value_out,
    output logic [bve_pkg::COUNT_W-1:0]         count,
    output logic [bve_pkg::COUNT_W-1:0]         room,
    output logic [bve_pkg::BUCKET_W-1:0]        bucket,
    output logic [bve_pkg::OFFSET_W-1:0]        offset
);

    import bve_pkg::*;

    bve_cmd_t cmd;

    // sequencing
    bve_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // counters, memory and result
    bve_datapath #(
        .FIRST_BUCKET (FIRST_BUCKET),
        .LEVELS       (LEVELS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (kind),
        .index     (index),
        .value_in  (value_in),
        .status    (status),
        .value_out (value_out),
        .count     (count),
        .room      (room),
        .bucket    (bucket),
        .offset    (offset)
    );

    // checks
    `BVE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second item taken during access")
    `BVE_ASSERT_NOW(a_take_load_apart, cmd.take, !cmd.load, "take and load in the same cycle")
    `BVE_ASSERT_NOW(a_count_le_room, out_valid, count <= room, "count above room")
    `BVE_ASSERT_NOW(a_error_zero, out_valid && (status != ST_OK), (value_out == '0) && (bucket == '0) && (offset == '0), "error result not zeroed")

endmodule

@@ rtl/bve_ram.sv @@
module bve_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ rtl/bve_ctrl.sv @@
module bve_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output bve_pkg::bve_cmd_t  cmd
);

    import bve_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // handshake and commands
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.take  = in_valid && (state_reg == S_IDLE);
    assign cmd.load  = (state_reg == S_LOAD) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/bve_datapath.sv @@
module bve_datapath #(
    parameter int FIRST_BUCKET = bve_pkg::FIRST_BUCKET_DEF,
    parameter int LEVELS       = bve_pkg::LEVELS_DEF,
    parameter int DATA_WIDTH   = bve_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bve_pkg::bve_cmd_t                   cmd,
    input  logic [bve_pkg::KIND_W-1:0]          kind,
    input  logic [bve_pkg::INDEX_W-1:0]         index,
    input  logic signed [bve_pkg::VALUE_W-1:0]  value_in,
    output logic [bve_pkg::STATUS_W-1:0]        status,
    output logic signed [bve_pkg::VALUE_W-1:0]  value_out,
    output logic [bve_pkg::COUNT_W-1:0]         count,
    output logic [bve_pkg::COUNT_W-1:0]         room,
    output logic [bve_pkg::BUCKET_W-1:0]        bucket,
    output logic [bve_pkg::OFFSET_W-1:0]        offset
);

    import bve_pkg::*;

    localparam int MAX_ROOM = FIRST_BUCKET * ((1 << LEVELS) - 1);
    localparam int CW       = $clog2(MAX_ROOM + 1);
    localparam int AW       = (MAX_ROOM > 1) ? $clog2(MAX_ROOM) : 1;
    localparam int XW       = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int PW       = $clog2(MAX_ROOM + FIRST_BUCKET);
    localparam int HBW      = (PW > 1) ? $clog2(PW) : 1;
    localparam int FB_LOG   = $clog2(FIRST_BUCKET + 1) - 1;

    logic [CW-1:0]         fill_reg;
    logic [CW-1:0]         fill_next;
    logic [CW-1:0]         limit_reg;
    logic [CW-1:0]         limit_next;

    logic [STATUS_W-1:0]   pend_status_reg;
    logic [STATUS_W-1:0]   pend_status_next;
    logic [AW-1:0]         pend_addr_reg;
    logic                  pend_rd_reg;
    logic                  pend_rd_next;

    logic [STATUS_W-1:0]   out_status_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [COUNT_W-1:0]    out_room_reg;
    logic [BUCKET_W-1:0]   out_bucket_reg;
    logic [OFFSET_W-1:0]   out_offset_reg;

    logic                  mem_en;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [XW-1:0]         idx_x;
    logic [XW-1:0]         fill_x;
    logic                  in_range;
    logic                  is_full;

    logic [PW-1:0]         pos;
    logic [HBW-1:0]        hb;
    logic [BUCKET_W-1:0]   loc_bucket;
    logic [OFFSET_W-1:0]   loc_offset;

    assign idx_x     = XW'(index);
    assign fill_x    = XW'(fill_reg);
    assign in_range  = (idx_x < fill_x);
    assign is_full   = (fill_reg >= limit_reg);
    assign mem_wdata = DATA_WIDTH'($unsigned(value_in));

    // operation decode, counter update and memory command
    always_comb
    begin
        fill_next        = fill_reg;
        limit_next       = limit_reg;
        pend_status_next = ST_OK;
        pend_rd_next     = 1'b0;
        mem_en           = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = AW'(fill_reg);
        if (cmd.take)
        begin
            case (kind)
                OP_PUSH:
                begin
                    if (is_full && (limit_reg >= CW'(MAX_ROOM)))
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        if (is_full)
                        begin
                            limit_next = (limit_reg << 1) + CW'(FIRST_BUCKET);
                        end
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = AW'(fill_reg);
                        fill_next = fill_reg + CW'(1);
                    end
                end
                OP_POP:
                begin
                    if (fill_reg == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        fill_next    = fill_reg - CW'(1);
                        mem_en       = 1'b1;
                        mem_addr     = AW'(fill_reg - CW'(1));
                        pend_rd_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (!in_range)
                    begin
                        pend_status_next = ST_RANGE;
                    end
                    else
                    begin
                        mem_en       = 1'b1;
                        mem_addr     = AW'(index);
                        pend_rd_next = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    if (!in_range)
                    begin
                        pend_status_next = ST_RANGE;
                    end
                    else
                    begin
                        mem_en   = 1'b1;
                        mem_we   = 1'b1;
                        mem_addr = AW'(index);
                    end
                end
                default:
                begin
                    pend_status_next = ST_OK;
                end
            endcase
        end
    end

    // element memory
    bve_ram #(
        .WIDTH  (DATA_WIDTH),
        .DEPTH  (MAX_ROOM),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // bucket and offset of the addressed element
    always_comb
    begin
        pos = PW'(pend_addr_reg) + PW'(FIRST_BUCKET);
        hb  = '0;
        for (int b = 0; b < PW; b++)
        begin
            if (pos[b])
            begin
                hb = HBW'(b);
            end
        end
        loc_bucket = BUCKET_W'(hb - HBW'(FB_LOG));
        loc_offset = OFFSET_W'(pos & ~(PW'(1) << hb));
    end

    // size and capacity counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            limit_reg <= CW'(FIRST_BUCKET);
        end
        else
        begin
            fill_reg  <= fill_next;
            limit_reg <= limit_next;
        end
    end

    // operation held while the memory read completes
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pend_status_reg <= pend_status_next;
            pend_addr_reg   <= mem_addr;
            pend_rd_reg     <= pend_rd_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_rd_reg ? VALUE_W'(mem_rdata) : '0;
            out_count_reg  <= COUNT_W'(fill_reg);
            out_room_reg   <= COUNT_W'(limit_reg);
            out_bucket_reg <= (pend_status_reg == ST_OK) ? loc_bucket : '0;
            out_offset_reg <= (pend_status_reg == ST_OK) ? loc_offset : '0;
        end
    end

    assign status    = out_status_reg;
    assign value_out = $signed(out_value_reg);
    assign count     = out_count_reg;
    assign room      = out_room_reg;
    assign bucket    = out_bucket_reg;
    assign offset    = out_offset_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import bve_pkg::*;

    localparam int FB          = FIRST_BUCKET_DEF;
    localparam int MAX_ROOM    = FB * ((1 << LEVELS_DEF) - 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] data;
    } vec_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  room;
        logic [BUCKET_W-1:0] bucket;
        logic [OFFSET_W-1:0] offset;
    } vec_res_t;

    // clock and block ports
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [KIND_W-1:0]          kind      = '0;
    logic [INDEX_W-1:0]         index     = '0;
    logic signed [VALUE_W-1:0]  value_in  = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]         count;
    logic [COUNT_W-1:0]         room;
    logic [BUCKET_W-1:0]        bucket;
    logic [OFFSET_W-1:0]        offset;

    // shadow copy of the vector
    logic [VALUE_W-1:0] shadow_elems [MAX_ROOM];
    int unsigned        shadow_fill = 0;
    int unsigned        shadow_room = FB;

    vec_op_t     ops_to_send [$];
    vec_res_t    results_due [$];
    vec_op_t     next_op;
    vec_res_t    got_res;
    vec_res_t    want_res;
    int unsigned gen_fill  = 0;
    int          n_sent    = 0;
    int          n_fail    = 0;
    int          cycles    = 0;
    logic        hold_rx   = 1'b0;

    bucketed_vector_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .index     (index),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value_out (value_out),
        .count     (count),
        .room      (room),
        .bucket    (bucket),
        .offset    (offset)
    );

    always #5 clk = ~clk;

    // position of the highest one bit
    function automatic int top_one(int unsigned v);
        int hb;
        for (hb = 0; (v >> (hb + 1)) != 0; hb++);
        return hb;
    endfunction

    // bucket and offset of element i
    function automatic void place_of(int unsigned i, output logic [BUCKET_W-1:0] bkt,
                                     output logic [OFFSET_W-1:0] off);
        int unsigned pos;
        int          hb;
        pos = i + FB;
        hb  = top_one(pos);
        bkt = BUCKET_W'(hb - top_one(FB));
        off = OFFSET_W'(pos ^ (1 << hb));
    endfunction

    // apply one operation to the shadow vector and return its result
    function automatic vec_res_t apply_vector_op(vec_op_t op);
        vec_res_t    r;
        int unsigned at;
        logic        hit;
        r   = '0;
        at  = 0;
        hit = 1'b0;
        case (op.kind)
            OP_PUSH:
            begin
                if (shadow_fill >= shadow_room && shadow_room >= MAX_ROOM)
                    r.status = ST_FULL;
                else
                begin
                    if (shadow_fill >= shadow_room)
                        shadow_room = 2 * shadow_room + FB;
                    shadow_elems[shadow_fill] = op.data;
                    at  = shadow_fill;
                    hit = 1'b1;
                    shadow_fill++;
                end
            end
            OP_POP:
            begin
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_fill--;
                    r.value = shadow_elems[shadow_fill];
                    at  = shadow_fill;
                    hit = 1'b1;
                end
            end
            OP_READ:
            begin
                if (op.index >= shadow_fill)
                    r.status = ST_RANGE;
                else
                begin
                    r.value = shadow_elems[op.index];
                    at  = op.index;
                    hit = 1'b1;
                end
            end
            default:
            begin
                if (op.index >= shadow_fill)
                    r.status = ST_RANGE;
                else
                begin
                    shadow_elems[op.index] = op.data;
                    at  = op.index;
                    hit = 1'b1;
                end
            end
        endcase
        r.count = COUNT_W'(shadow_fill);
        r.room  = COUNT_W'(shadow_room);
        if (hit)
            place_of(at, r.bucket, r.offset);
        return r;
    endfunction

    // idling mix rotates every 128 items
    function automatic int tx_idle_pct();
        case ((n_sent >> 7) & 3)
            1:       return 87;
            3:       return 32;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_stall_pct();
        case ((n_sent >> 7) & 3)
            2:       return 87;
            3:       return 32;
            default: return 0;
        endcase
    endfunction

    // queue one item, tracking the fill it leads to
    task automatic queue_op(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] idx,
                            logic [VALUE_W-1:0] d);
        vec_op_t op;
        op.kind  = k;
        op.index = idx;
        op.data  = d;
        if (k == OP_PUSH && gen_fill < MAX_ROOM)
            gen_fill++;
        else if (k == OP_POP && gen_fill > 0)
            gen_fill--;
        ops_to_send.push_back(op);
    endtask

    // random operations with a given push and pop share in percent
    task automatic queue_random_ops(int n, int push_pct, int pop_pct);
        int unsigned        pick;
        logic [INDEX_W-1:0] idx;
        logic [KIND_W-1:0]  k;
        repeat (n)
        begin
            pick = $urandom_range(99);
            idx  = INDEX_W'($urandom);
            if (pick < push_pct)
                k = OP_PUSH;
            else if (pick < push_pct + pop_pct)
                k = OP_POP;
            else
            begin
                k    = $urandom_range(1) ? OP_WRITE : OP_READ;
                pick = $urandom_range(9);
                // mostly in range, with the boundary on both sides
                if (pick < 7 && gen_fill > 0)
                    idx = INDEX_W'($urandom_range(gen_fill - 1));
                else if (pick == 7)
                    idx = INDEX_W'(gen_fill);
                else if (pick == 8 && gen_fill > 0)
                    idx = INDEX_W'(gen_fill - 1);
            end
            queue_op(k, idx, $urandom);
        end
    endtask

    // sender pause until the block has drained
    task automatic wait_drained();
        while (ops_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    // input side: predict on accept, then offer the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                results_due.push_back(apply_vector_op({kind, index, value_in}));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (ops_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct())
                begin
                    next_op = ops_to_send.pop_front();
                    kind     <= next_op.kind;
                    index    <= next_op.index;
                    value_in <= next_op.data;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_rx || ($urandom_range(99) < rx_stall_pct());
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (n_sent >= 300);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = {status, value_out, count, room, bucket, offset};
            if (results_due.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result at %0t: status=%0d value=%h count=%0d",
                             $time, status, value_out, count);
            end
            else
            begin
                want_res = results_due.pop_front();
                if (got_res.status !== want_res.status || got_res.value !== want_res.value ||
                    got_res.count !== want_res.count || got_res.room !== want_res.room ||
                    got_res.bucket !== want_res.bucket || got_res.offset !== want_res.offset)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                    begin
                        $write("mismatch at %0t: exp st=%0d val=%h cnt=%0d room=%0d bkt=%0d off=%0d",
                               $time, want_res.status, want_res.value, want_res.count,
                               want_res.room, want_res.bucket, want_res.offset);
                        $display(" / got st=%0d val=%h cnt=%0d room=%0d bkt=%0d off=%0d",
                                 got_res.status, got_res.value, got_res.count,
                                 got_res.room, got_res.bucket, got_res.offset);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // reset and stimulus
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty vector errors
        queue_op(OP_POP,   '0,  '0);
        queue_op(OP_READ,  '0,  '0);
        queue_op(OP_WRITE, '1,  '0);
        // pushes with extreme data, second bucket opened by the third
        queue_op(OP_PUSH,  '0,  32'h7fff_ffff);
        queue_op(OP_PUSH,  '1,  32'h8000_0000);
        queue_op(OP_PUSH,  '0,  32'h0000_0000);
        queue_op(OP_PUSH,  '0,  32'hffff_ffff);
        queue_op(OP_READ,  9'd0, '0);
        queue_op(OP_READ,  9'd1, '0);
        queue_op(OP_READ,  9'd2, '0);
        queue_op(OP_READ,  9'd3, '0);
        queue_op(OP_WRITE, 9'd1, 32'h5555_5555);
        queue_op(OP_WRITE, 9'd3, 32'haaaa_aaaa);
        queue_op(OP_READ,  9'd1, '0);
        queue_op(OP_READ,  9'd3, '0);
        // index at and beyond fill, including above the element range
        queue_op(OP_READ,  9'd4, '0);
        queue_op(OP_READ,  '1,   '0);
        queue_op(OP_WRITE, 9'd510, 32'hffff_ffff);
        // drain back to empty and pop once more
        repeat (4) queue_op(OP_POP, '0, '0);
        queue_op(OP_POP,   '1,  '0);
        queue_op(OP_PUSH,  '1,  32'h0000_0001);
        queue_op(OP_PUSH,  '0,  32'h1234_5678);
        wait_drained();

        // mixed traffic, then growth to maximum capacity, then shrinking
        queue_random_ops(150, 40, 30);
        wait_drained();
        queue_random_ops(620, 85, 3);
        wait_drained();
        queue_random_ops(330, 3, 90);
        wait_drained();

        repeat (10) @(negedge clk);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
